### src/r2y_pkg.sv
// ----------------------------------------------------------------------------
// r2y_pkg
// Shared constants, types and the sample clamp for the RGB to YUV 4:2:0 packer.
// ----------------------------------------------------------------------------
package r2y_pkg;

	localparam int ADDR_W   = 25;
	localparam int CHROMA_W = 23;
	localparam int SUM_W    = 18;
	localparam int DIM_W    = 13;
	localparam int LAYOUT_W = 2;
	localparam int PADDR_W  = 4;
	localparam int PDATA_W  = 32;

	localparam int DEFAULT_MAX_WIDTH  = 4096;
	localparam int DEFAULT_MAX_HEIGHT = 4096;
	localparam int RESET_WIDTH        = 640;
	localparam int RESET_HEIGHT       = 480;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_LAYOUT = 2'd2;

	localparam logic [LAYOUT_W-1:0] LAYOUT_NV12 = 2'd0;
	localparam logic [LAYOUT_W-1:0] LAYOUT_NV21 = 2'd1;

	localparam logic [1:0] PLANE_Y = 2'd0;
	localparam logic [1:0] PLANE_U = 2'd1;
	localparam logic [1:0] PLANE_V = 2'd2;

	localparam logic signed [10:0] Y_OFFSET = 11'sd16;
	localparam logic signed [10:0] C_OFFSET = 11'sd128;

	typedef struct packed {
		logic                     chroma;
		logic [1:0]               plane_a;
		logic [1:0]               plane_b;
		logic [ADDR_W-1:0]        luma_addr;
		logic [ADDR_W-1:0]        addr_a;
		logic [ADDR_W-1:0]        addr_b;
		logic signed [SUM_W-1:0]  y_sum;
		logic signed [SUM_W-1:0]  u_sum;
		logic signed [SUM_W-1:0]  v_sum;
	} r2y_item_t;

	// floor(sum / 256) + offset, clamped to a byte
	function automatic logic [7:0] clamp_sample(input logic signed [SUM_W-1:0] sum,
		input logic signed [10:0] offset);
		logic signed [10:0] q;
		q = {sum[SUM_W-1], sum[SUM_W-1:8]};
		q = q + offset;
		if (q < 11'sd0) begin
			return 8'd0;
		end else if (q > 11'sd255) begin
			return 8'd255;
		end
		return q[7:0];
	endfunction

endpackage

### src/r2y_front.sv
// ----------------------------------------------------------------------------
// r2y_front
// Accepts pixels, tracks raster position, forms colour sums and addresses.
// ----------------------------------------------------------------------------
module r2y_front #(
	parameter int MAX_WIDTH  = r2y_pkg::DEFAULT_MAX_WIDTH,
	parameter int MAX_HEIGHT = r2y_pkg::DEFAULT_MAX_HEIGHT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                pixel_valid,
	output logic                                pixel_ready,
	input  logic [23:0]                         pixel_rgb,
	input  logic [$clog2(MAX_WIDTH+1)-1:0]      ew,
	input  logic [$clog2(MAX_HEIGHT+1)-1:0]     eh,
	input  logic [r2y_pkg::ADDR_W-1:0]          area,
	input  logic [r2y_pkg::LAYOUT_W-1:0]        layout,
	output logic                                push_valid,
	input  logic                                push_ready,
	output r2y_pkg::r2y_item_t                  push_item
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);

	logic [CW-1:0]                   col_q;
	logic [RW-1:0]                   row_q;
	logic [r2y_pkg::ADDR_W-1:0]      luma_q;
	logic [r2y_pkg::CHROMA_W-1:0]    chroma_q;

	logic [CW:0]                     col_inc;
	logic [RW:0]                     row_inc;
	logic                            col_wrap;
	logic                            row_wrap;
	logic                            accept;
	logic                            chroma;
	logic signed [r2y_pkg::SUM_W-1:0] rs, gs, bs;
	logic [r2y_pkg::ADDR_W-1:0]      c_ext;
	logic [r2y_pkg::ADDR_W-1:0]      c_dbl;

	assign pixel_ready = push_ready;
	assign push_valid  = pixel_valid;
	assign accept      = pixel_valid && push_ready;

	assign chroma   = !col_q[0] && !row_q[0];
	assign col_inc  = {1'b0, col_q} + 1'b1;
	assign row_inc  = {1'b0, row_q} + 1'b1;
	assign col_wrap = col_inc >= (CW+1)'(ew);
	assign row_wrap = row_inc >= (RW+1)'(eh);

	assign rs = r2y_pkg::SUM_W'(pixel_rgb[23:16]);
	assign gs = r2y_pkg::SUM_W'(pixel_rgb[15:8]);
	assign bs = r2y_pkg::SUM_W'(pixel_rgb[7:0]);

	assign c_ext = r2y_pkg::ADDR_W'(chroma_q);
	assign c_dbl = {1'b0, chroma_q, 1'b0};

	always_comb begin
		push_item.chroma    = chroma;
		push_item.luma_addr = luma_q;
		push_item.y_sum = 18'sd66 * rs + 18'sd129 * gs + 18'sd25 * bs + 18'sd128;
		push_item.u_sum = 18'sd112 * bs - 18'sd38 * rs - 18'sd74 * gs + 18'sd128;
		push_item.v_sum = 18'sd112 * rs - 18'sd94 * gs - 18'sd18 * bs + 18'sd128;
		case (layout)
			r2y_pkg::LAYOUT_NV12: begin
				push_item.plane_a = r2y_pkg::PLANE_U;
				push_item.plane_b = r2y_pkg::PLANE_V;
				push_item.addr_a  = area + c_dbl;
				push_item.addr_b  = area + (c_dbl | r2y_pkg::ADDR_W'(1));
			end
			r2y_pkg::LAYOUT_NV21: begin
				push_item.plane_a = r2y_pkg::PLANE_V;
				push_item.plane_b = r2y_pkg::PLANE_U;
				push_item.addr_a  = area + c_dbl;
				push_item.addr_b  = area + (c_dbl | r2y_pkg::ADDR_W'(1));
			end
			default: begin
				push_item.plane_a = r2y_pkg::PLANE_U;
				push_item.plane_b = r2y_pkg::PLANE_V;
				push_item.addr_a  = area + c_ext;
				push_item.addr_b  = area + (area >> 2) + c_ext;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			luma_q   <= '0;
			chroma_q <= '0;
		end else if (accept) begin
			if (!col_wrap) begin
				col_q    <= col_inc[CW-1:0];
				luma_q   <= luma_q + 1'b1;
				chroma_q <= chroma_q + r2y_pkg::CHROMA_W'(chroma);
			end else if (!row_wrap) begin
				col_q    <= '0;
				row_q    <= row_inc[RW-1:0];
				luma_q   <= luma_q + 1'b1;
				chroma_q <= chroma_q + r2y_pkg::CHROMA_W'(chroma);
			end else begin
				col_q    <= '0;
				row_q    <= '0;
				luma_q   <= '0;
				chroma_q <= '0;
			end
		end
	end

endmodule

### src/r2y_queue.sv
// ----------------------------------------------------------------------------
// r2y_queue
// Short register queue between the pixel front end and the result back end.
// ----------------------------------------------------------------------------
module r2y_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	output logic               push_ready,
	input  r2y_pkg::r2y_item_t push_item,
	output logic               pop_valid,
	input  logic               pop_ready,
	output r2y_pkg::r2y_item_t pop_item
);

	localparam int AW = $clog2(r2y_pkg::QUEUE_DEPTH);

	r2y_pkg::r2y_item_t mem_q [r2y_pkg::QUEUE_DEPTH];
	logic [AW-1:0]      wr_q;
	logic [AW-1:0]      rd_q;
	logic [AW:0]        count_q;
	logic               push;
	logic               pop;

	assign push_ready = count_q != (AW+1)'(r2y_pkg::QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_item   = mem_q[rd_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### src/r2y_back.sv
// ----------------------------------------------------------------------------
// r2y_back
// Expands each queued pixel into its luma and chroma results, one a cycle unless stalled.
// ----------------------------------------------------------------------------
module r2y_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        pop_valid,
	output logic                        pop_ready,
	input  r2y_pkg::r2y_item_t          pop_item,
	output logic                        result_valid,
	input  logic                        result_ready,
	output logic [1:0]                  plane,
	output logic [r2y_pkg::ADDR_W-1:0]  address,
	output logic [7:0]                  sample,
	output logic                        last_of_pixel
);

	typedef enum logic [1:0] {
		STEP_Y,
		STEP_FIRST,
		STEP_SECOND
	} step_t;

	step_t                       step_q;
	logic                        out_valid_q;
	logic [1:0]                  plane_q;
	logic [r2y_pkg::ADDR_W-1:0]  address_q;
	logic [7:0]                  sample_q;
	logic                        last_q;

	logic                        load;
	logic                        emit;
	logic [1:0]                  sel_plane;
	logic [r2y_pkg::ADDR_W-1:0]  sel_addr;
	logic                        sel_last;
	logic [7:0]                  sel_sample;
	step_t                       step_next;

	assign load      = !out_valid_q || result_ready;
	assign emit      = load && pop_valid;
	assign pop_ready = load && sel_last;

	always_comb begin
		case (step_q)
			STEP_Y: begin
				sel_plane = r2y_pkg::PLANE_Y;
				sel_addr  = pop_item.luma_addr;
				sel_last  = !pop_item.chroma;
				step_next = STEP_FIRST;
			end
			STEP_FIRST: begin
				sel_plane = pop_item.plane_a;
				sel_addr  = pop_item.addr_a;
				sel_last  = 1'b0;
				step_next = STEP_SECOND;
			end
			default: begin
				sel_plane = pop_item.plane_b;
				sel_addr  = pop_item.addr_b;
				sel_last  = 1'b1;
				step_next = STEP_Y;
			end
		endcase
		case (sel_plane)
			r2y_pkg::PLANE_U: sel_sample = r2y_pkg::clamp_sample(pop_item.u_sum, r2y_pkg::C_OFFSET);
			r2y_pkg::PLANE_V: sel_sample = r2y_pkg::clamp_sample(pop_item.v_sum, r2y_pkg::C_OFFSET);
			default:          sel_sample = r2y_pkg::clamp_sample(pop_item.y_sum, r2y_pkg::Y_OFFSET);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			step_q      <= STEP_Y;
		end else if (load) begin
			out_valid_q <= pop_valid;
			if (emit) begin
				step_q <= sel_last ? STEP_Y : step_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			plane_q   <= sel_plane;
			address_q <= sel_addr;
			sample_q  <= sel_sample;
			last_q    <= sel_last;
		end
	end

	assign result_valid  = out_valid_q;
	assign plane         = plane_q;
	assign address       = address_q;
	assign sample        = sample_q;
	assign last_of_pixel = last_q;

endmodule

### src/rgb_to_yuv420_packer.sv
// ----------------------------------------------------------------------------
// rgb_to_yuv420_packer
// RGB pixel stream to BT.601 YUV 4:2:0 samples with NV12, NV21 or I420 addresses.
// ----------------------------------------------------------------------------
// Pixels enter on pixel_valid/pixel_ready in raster order, one per accepted
// item. Each pixel gives a luma result; pixels on even rows and even columns
// give two chroma results after it. Results leave on result_valid/result_ready
// with plane, buffer address, sample and a flag on the last result of a pixel.
// A pixel is taken into a four-entry queue; from the queue entry its first result
// is registered at the output. The result port moves one result a cycle unless
// result_ready stalls it, so a pixel gives one result, or three with chroma.
// Frame size and layout must be set over the APB port while the stream is idle;
// the block does not enforce it. The luma area is recomputed on the write itself.
// Reset returns 640 by 480, NV12, and the start of a frame; no clearing pass.
// A stalled receiver holds the current result; the queue keeps taking pixels
// until it fills, after which pixel_ready falls.
// ----------------------------------------------------------------------------
module rgb_to_yuv420_packer #(
	parameter int MAX_WIDTH  = r2y_pkg::DEFAULT_MAX_WIDTH,
	parameter int MAX_HEIGHT = r2y_pkg::DEFAULT_MAX_HEIGHT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [r2y_pkg::PADDR_W-1:0]   paddr,
	input  logic [r2y_pkg::PDATA_W-1:0]   pwdata,
	output logic [r2y_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	input  logic                          pixel_valid,
	output logic                          pixel_ready,
	input  logic [23:0]                   pixel_rgb,
	output logic                          result_valid,
	input  logic                          result_ready,
	output logic [1:0]                    plane,
	output logic [r2y_pkg::ADDR_W-1:0]    address,
	output logic [7:0]                    sample,
	output logic                          last_of_pixel
);

	localparam int EW_W = $clog2(MAX_WIDTH + 1);
	localparam int EH_W = $clog2(MAX_HEIGHT + 1);
	localparam int RST_EW = (r2y_pkg::RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH
		: r2y_pkg::RESET_WIDTH;
	localparam int RST_EH = (r2y_pkg::RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT
		: r2y_pkg::RESET_HEIGHT;
	localparam logic [r2y_pkg::ADDR_W-1:0] RST_AREA = r2y_pkg::ADDR_W'(RST_EW * RST_EH);

	logic [r2y_pkg::DIM_W-1:0]     fw_q;
	logic [r2y_pkg::DIM_W-1:0]     fh_q;
	logic [r2y_pkg::LAYOUT_W-1:0]  layout_q;
	logic [EW_W-1:0]               ew_q;
	logic [EH_W-1:0]               eh_q;
	logic [r2y_pkg::ADDR_W-1:0]    area_q;

	logic                          wr;
	logic [1:0]                    idx;
	logic [r2y_pkg::DIM_W-1:0]     new_fw;
	logic [r2y_pkg::DIM_W-1:0]     new_fh;
	logic [EW_W-1:0]               new_ew;
	logic [EH_W-1:0]               new_eh;
	logic [EW_W+EH_W-1:0]          prod;

	logic                          push_valid;
	logic                          push_ready;
	r2y_pkg::r2y_item_t            push_item;
	logic                          pop_valid;
	logic                          pop_ready;
	r2y_pkg::r2y_item_t            pop_item;

	assign pready = 1'b1;
	assign idx    = paddr[3:2];
	assign wr     = psel && penable && pwrite;

	always_comb begin
		new_fw = (wr && idx == r2y_pkg::REG_WIDTH) ? pwdata[r2y_pkg::DIM_W-1:0] : fw_q;
		new_fh = (wr && idx == r2y_pkg::REG_HEIGHT) ? pwdata[r2y_pkg::DIM_W-1:0] : fh_q;
		if (new_fw < r2y_pkg::DIM_W'(2)) begin
			new_ew = EW_W'(2);
		end else if ({1'b0, new_fw} > (r2y_pkg::DIM_W+1)'(MAX_WIDTH)) begin
			new_ew = EW_W'(MAX_WIDTH);
		end else begin
			new_ew = EW_W'(new_fw);
		end
		if (new_fh < r2y_pkg::DIM_W'(2)) begin
			new_eh = EH_W'(2);
		end else if ({1'b0, new_fh} > (r2y_pkg::DIM_W+1)'(MAX_HEIGHT)) begin
			new_eh = EH_W'(MAX_HEIGHT);
		end else begin
			new_eh = EH_W'(new_fh);
		end
		prod = (EW_W+EH_W)'(new_ew) * (EW_W+EH_W)'(new_eh);
	end

	always_comb begin
		case (idx)
			r2y_pkg::REG_WIDTH:  prdata = r2y_pkg::PDATA_W'(fw_q);
			r2y_pkg::REG_HEIGHT: prdata = r2y_pkg::PDATA_W'(fh_q);
			r2y_pkg::REG_LAYOUT: prdata = r2y_pkg::PDATA_W'(layout_q);
			default:             prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q     <= r2y_pkg::DIM_W'(r2y_pkg::RESET_WIDTH);
			fh_q     <= r2y_pkg::DIM_W'(r2y_pkg::RESET_HEIGHT);
			layout_q <= r2y_pkg::LAYOUT_NV12;
			ew_q     <= EW_W'(RST_EW);
			eh_q     <= EH_W'(RST_EH);
			area_q   <= RST_AREA;
		end else if (wr) begin
			fw_q   <= new_fw;
			fh_q   <= new_fh;
			ew_q   <= new_ew;
			eh_q   <= new_eh;
			area_q <= r2y_pkg::ADDR_W'(prod);
			if (idx == r2y_pkg::REG_LAYOUT) begin
				layout_q <= pwdata[r2y_pkg::LAYOUT_W-1:0];
			end
		end
	end

	r2y_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_valid (pixel_valid),
		.pixel_ready (pixel_ready),
		.pixel_rgb   (pixel_rgb),
		.ew          (ew_q),
		.eh          (eh_q),
		.area        (area_q),
		.layout      (layout_q),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_item   (push_item)
	);

	r2y_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	r2y_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.pop_valid     (pop_valid),
		.pop_ready     (pop_ready),
		.pop_item      (pop_item),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.plane         (plane),
		.address       (address),
		.sample        (sample),
		.last_of_pixel (last_of_pixel)
	);

endmodule
